// ----- sv/assert_macros.svh -----
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define BB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked property that also holds during reset
`define BB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- sv/bb3_pkg.sv -----
package bb3_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WCFG_W      = 12;
   localparam int HCFG_W      = 16;
   localparam int ROW_W       = HCFG_W + 1;
   localparam int CMP_W       = (COL_W + 1 > WCFG_W) ? COL_W + 1 : WCFG_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [WCFG_W-1:0] RESET_WIDTH  = WCFG_W'(640);
   localparam logic [HCFG_W-1:0] RESET_HEIGHT = HCFG_W'(480);

   localparam int WIN_SIZE    = 9;
   localparam int SUM_W       = 12;
   localparam int CNT_W       = 4;
   localparam int MEAN_X_W    = SUM_W + 1;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 18;
   localparam int PROD_W      = MEAN_X_W + RECIP_W;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // index col*3 + row, col 0 oldest, row 0 top
   typedef pixel_type [WIN_SIZE-1:0] window_type;

   typedef struct packed {
      logic left;
      logic right;
      logic top;
      logic bottom;
   } edge_type;

   typedef struct packed {
      logic sum_en;
      logic mul_en;
   } mean_ctrl_type;

   // ceil(2^RECIP_SHIFT / (2n)); exact for every 2*sum + n below 2^13
   function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
      logic [RECIP_W-1:0] m;
      case (n)
         CNT_W'(1): m = RECIP_W'(131072);
         CNT_W'(2): m = RECIP_W'(65536);
         CNT_W'(3): m = RECIP_W'(43691);
         CNT_W'(4): m = RECIP_W'(32768);
         CNT_W'(6): m = RECIP_W'(21846);
         CNT_W'(9): m = RECIP_W'(14564);
         default:   m = '0;
      endcase
      return m;
   endfunction

endpackage

// ----- sv/box_blur_3x3_edge_aware_unit.sv -----
// a pixel beat that completes a neighborhood passes the read, sum, multiply and hold states
// one beat at a time: no new beat is taken until the line memory read-modify-write and, for
//   a beat with a result, the two-stage mean datapath and the hand-off are through
// padding beats inside the frame are dropped on accept, without leaving the idle state
// reset: synchronous, active high; counters, window and control cleared, sizes 640 x 480;
//   line memories are not cleared (entries never written only land on masked positions)
module box_blur_3x3_edge_aware_unit (
   input  logic                                clock,
   input  logic                                reset,
   // input pixels
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // red_in, green_in, blue_in
   input  logic                                req_tuser,  // is_padding
   // blurred pixels
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,  // red_out, green_out, blue_out
   output logic                                rsp_tlast,  // frame_end
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bb3_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]      csr_data
);
   import bb3_pkg::*;

   // one-hot sequencer: accept, memory read-modify-write, sum, multiply, hand off
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_HOLD = 5'b10000
   } state_type;

   state_type             state_ff, state_in;

   // configuration
   logic [WCFG_W-1:0]     frame_width_ff, frame_width_in;
   logic [HCFG_W-1:0]     frame_height_ff, frame_height_in;
   logic [CMP_W-1:0]      eff_w;
   logic [HCFG_W-1:0]     eff_h;

   // raster counters
   logic [COL_W-1:0]      in_col_ff, in_col_in;
   logic [ROW_W-1:0]      in_row_ff, in_row_in;
   logic [COL_W-1:0]      out_col_ff, out_col_in;
   logic [HCFG_W-1:0]     out_row_ff, out_row_in;

   // per item context
   pixel_type             pix_ff, pix_in;
   logic [COL_W-1:0]      addr_ff, addr_in;
   logic                  emit_ff, emit_in;
   logic                  last_ff, last_in;
   edge_type              edges_ff, edges_in;

   // line memories, upper row and middle row
   pixel_type             upper_mem  [MAX_WIDTH];
   pixel_type             middle_mem [MAX_WIDTH];
   pixel_type             up_rd_ff;
   pixel_type             mid_rd_ff;
   logic                  mem_re;
   logic                  mem_we;

   window_type            win_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   pixel_type             rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   mean_ctrl_type         mean_ctrl;
   pixel_type             mean;

   logic                  req_accept;
   logic                  csr_write;
   logic                  drain;
   logic                  skip;
   logic                  emit;
   logic                  col_wrap;
   edge_type              edges_now;
   logic                  last_now;
   logic                  rsp_load;
   pixel_type             req_pix;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   // out of range sizes clamp: width 0 acts as 1, above the memory depth acts as the depth
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = CMP_W'(1);
      end else if (CMP_W'(frame_width_ff) > CMP_W'(MAX_WIDTH)) begin
         eff_w = CMP_W'(MAX_WIDTH);
      end else begin
         eff_w = CMP_W'(frame_width_ff);
      end
      eff_h = (frame_height_ff == '0) ? HCFG_W'(1) : frame_height_ff;
   end

   assign req_pix.red   = req_tdata[7:0];
   assign req_pix.green = req_tdata[15:8];
   assign req_pix.blue  = req_tdata[23:16];

   // all pixels of the frame are in: every beat only drains
   assign drain    = in_row_ff >= ROW_W'(eff_h);
   // padding while pixels are still expected is dropped
   assign skip     = !drain && req_tuser;
   // first result once the window is one row and one pixel ahead
   assign emit     = (in_row_ff >= ROW_W'(2)) ||
                     ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
   assign col_wrap = (CMP_W'(in_col_ff) + CMP_W'(1)) >= eff_w;

   // which neighbors of the output pixel lie inside the frame
   assign edges_now.left   = (out_col_ff != '0);
   assign edges_now.right  = (CMP_W'(out_col_ff) + CMP_W'(1)) < eff_w;
   assign edges_now.top    = (out_row_ff != '0);
   assign edges_now.bottom = (ROW_W'(out_row_ff) + ROW_W'(1)) < ROW_W'(eff_h);
   assign last_now         = !edges_now.right && !edges_now.bottom;

   assign rsp_load = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready);
   assign mem_re   = req_accept && !skip;
   assign mem_we   = (state_ff == ST_READ);

   assign mean_ctrl.sum_en = (state_ff == ST_SUM);
   assign mean_ctrl.mul_en = (state_ff == ST_MUL);

   always_comb begin
      state_in        = state_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      in_col_in       = in_col_ff;
      in_row_in       = in_row_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      pix_in          = pix_ff;
      addr_in         = addr_ff;
      emit_in         = emit_ff;
      last_in         = last_ff;
      edges_in        = edges_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && !skip) begin
               pix_in   = drain ? '0 : req_pix;
               addr_in  = in_col_ff;
               emit_in  = emit;
               edges_in = edges_now;
               last_in  = last_now;
               // advance the input raster position
               if (col_wrap) begin
                  in_col_in = '0;
                  in_row_in = in_row_ff + ROW_W'(1);
               end else begin
                  in_col_in = in_col_ff + COL_W'(1);
               end
               // advance the output raster position for the result this beat makes
               if (emit) begin
                  if ((CMP_W'(out_col_ff) + CMP_W'(1)) >= eff_w) begin
                     out_col_in = '0;
                     out_row_in = out_row_ff + HCFG_W'(1);
                  end else begin
                     out_col_in = out_col_ff + COL_W'(1);
                  end
                  // frame done: next beat starts a new frame
                  if (last_now) begin
                     in_col_in  = '0;
                     in_row_in  = '0;
                     out_col_in = '0;
                     out_row_in = '0;
                  end
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = emit_ff ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mean;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a width or height write restarts the frame and drops anything pending
      if (csr_write && ((csr_index == REG_FRAME_WIDTH) || (csr_index == REG_FRAME_HEIGHT))) begin
         if (csr_index == REG_FRAME_WIDTH) begin
            frame_width_in = csr_data[WCFG_W-1:0];
         end else begin
            frame_height_in = csr_data[HCFG_W-1:0];
         end
         in_col_in    = '0;
         in_row_in    = '0;
         out_col_in   = '0;
         out_row_in   = '0;
         rsp_valid_in = 1'b0;
         state_in     = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= RESET_WIDTH;
         frame_height_ff <= RESET_HEIGHT;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         emit_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         in_col_ff       <= in_col_in;
         in_row_ff       <= in_row_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
         emit_ff         <= emit_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      addr_ff     <= addr_in;
      last_ff     <= last_in;
      edges_ff    <= edges_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // read on accept, write back in the following cycle; one item at a time so no overlap
   always_ff @(posedge clock) begin
      if (mem_we) begin
         upper_mem[addr_ff] <= mid_rd_ff;
      end
      if (mem_re) begin
         up_rd_ff <= upper_mem[in_col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         middle_mem[addr_ff] <= pix_ff;
      end
      if (mem_re) begin
         mid_rd_ff <= middle_mem[in_col_ff];
      end
   end

   // window shifts one column per item, newest column from the memories and the pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (mem_we) begin
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= win_ff[k+3];
         end
         win_ff[6] <= up_rd_ff;
         win_ff[7] <= mid_rd_ff;
         win_ff[8] <= pix_ff;
      end
   end

   bb3_mean u_mean (
      .clock (clock),
      .ctrl  (mean_ctrl),
      .win   (win_ff),
      .edges (edges_ff),
      .mean  (mean)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.blue, rsp_data_ff.green, rsp_data_ff.red};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- sv/bb3_mean.sv -----
module bb3_mean (
   input  logic                  clock,
   input  bb3_pkg::mean_ctrl_type ctrl,
   input  bb3_pkg::window_type   win,
   input  bb3_pkg::edge_type     edges,
   output bb3_pkg::pixel_type    mean
);
   import bb3_pkg::*;

   logic [2:0]          col_ok;
   logic [2:0]          row_ok;
   logic [SUM_W-1:0]    sum_r, sum_g, sum_b;
   logic [CNT_W-1:0]    cnt;

   logic [SUM_W-1:0]    sum_r_ff, sum_g_ff, sum_b_ff;
   logic [RECIP_W-1:0]  recip_ff;
   logic [CNT_W-1:0]    n_ff;

   logic [MEAN_X_W-1:0] x_r, x_g, x_b;
   logic [PROD_W-1:0]   prod_r_ff, prod_g_ff, prod_b_ff;

   // masked neighborhood sums and count of neighbors inside the frame
   always_comb begin
      col_ok = {edges.right, 1'b1, edges.left};
      row_ok = {edges.bottom, 1'b1, edges.top};
      sum_r  = '0;
      sum_g  = '0;
      sum_b  = '0;
      cnt    = '0;
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            if (col_ok[j] && row_ok[i]) begin
               sum_r = sum_r + SUM_W'(win[j*3+i].red);
               sum_g = sum_g + SUM_W'(win[j*3+i].green);
               sum_b = sum_b + SUM_W'(win[j*3+i].blue);
               cnt   = cnt + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         sum_r_ff <= sum_r;
         sum_g_ff <= sum_g;
         sum_b_ff <= sum_b;
         n_ff     <= cnt;
         recip_ff <= recip_of(cnt);
      end
   end

   // (2*sum + n) / (2n) as multiply by reciprocal
   assign x_r = MEAN_X_W'({sum_r_ff, 1'b0}) + MEAN_X_W'(n_ff);
   assign x_g = MEAN_X_W'({sum_g_ff, 1'b0}) + MEAN_X_W'(n_ff);
   assign x_b = MEAN_X_W'({sum_b_ff, 1'b0}) + MEAN_X_W'(n_ff);

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_r_ff <= PROD_W'(x_r) * PROD_W'(recip_ff);
         prod_g_ff <= PROD_W'(x_g) * PROD_W'(recip_ff);
         prod_b_ff <= PROD_W'(x_b) * PROD_W'(recip_ff);
      end
   end

   assign mean.red   = prod_r_ff[RECIP_SHIFT +: 8];
   assign mean.green = prod_g_ff[RECIP_SHIFT +: 8];
   assign mean.blue  = prod_b_ff[RECIP_SHIFT +: 8];

endmodule

// ----- sv/bb3_checker.sv -----
`include "assert_macros.svh"

module bb3_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [bb3_pkg::CSR_INDEX_W-1:0] csr_index
);
   import bb3_pkg::*;

   // a stalled result beat stays offered
   `BB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // no result left over after reset
   `BB_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

   // a pixel beat always occupies the line memories the next cycle
   `BB_ASSERT(a_pixel_busy, clock, reset, req_tvalid && req_tready && !req_tuser |=> !req_tready)

   // a result never follows its input beat directly
   `BB_ASSERT(a_min_latency, clock, reset, $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))

   // a width or height write drops pending results
   `BB_ASSERT(a_cfg_flush, clock, reset,
      csr_valid && csr_ready && (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT)
      |=> !rsp_tvalid)

endmodule

bind box_blur_3x3_edge_aware_unit bb3_checker u_bb3_checker (.*);

// ----- dv/box_blur_3x3_edge_aware_unit_tb.sv -----
`timescale 1ns / 100ps

module box_blur_3x3_edge_aware_unit_tb;
   import bb3_pkg::*;

   // idle time before a register write, covers results still on their way out
   // and beats still inside the line memory pipeline
   localparam int SETTLE_CYCLES = 20;
   // cycles without any beat on any channel before the run is called hung
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_BEATS  = 850;
   localparam int MAX_REPORTS   = 40;
   localparam int IDLE_PCT      = 29;

   // index codes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_2 = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_3 = CSR_INDEX_W'(3);

   typedef struct packed {
      pixel_type px;
      logic      frame_end;
   } blurred_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata  = '0;   // red_in, green_in, blue_in
   logic                   req_tuser  = 1'b0; // is_padding
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;         // red_out, green_out, blue_out
   logic                   rsp_tlast;         // frame_end
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // predictor state: sizes, line memories, window and the four counters
   logic [WCFG_W-1:0] blur_width  = RESET_WIDTH;
   logic [HCFG_W-1:0] blur_height = RESET_HEIGHT;
   pixel_type         upper_row [MAX_WIDTH];
   pixel_type         middle_row [MAX_WIDTH];
   pixel_type         window_px [WIN_SIZE];
   int unsigned       in_col, in_row, out_col, out_row;

   blurred_type       expected_blur [$];
   blurred_type       next_blur;
   bit                frame_closed = 1'b0;
   bit                burst        = 1'b0; // no idling on either side
   bit                extreme_px   = 1'b0; // channels only 0 or 255

   int errors        = 0;
   int pixels_sent   = 0;
   int pads_sent     = 0;
   int results_seen  = 0;
   int frames_closed = 0;
   int reg_writes    = 0;
   int idle_cycles   = 0;

   box_blur_3x3_edge_aware_unit DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver backpressure, off during burst stretches
   always @(posedge clock) begin
      rsp_tready <= burst || ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
   endtask

   function automatic int unsigned active_width();
      if (blur_width == 0) return 1;
      if (blur_width > MAX_WIDTH) return MAX_WIDTH;
      return blur_width;
   endfunction

   function automatic int unsigned active_height();
      return (blur_height == 0) ? 1 : blur_height;
   endfunction

   function automatic void restart_frame();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function automatic void reset_blur_model();
      for (int k = 0; k < WIN_SIZE; k++) window_px[k] = '0;
      restart_frame();
      blur_width  = RESET_WIDTH;
      blur_height = RESET_HEIGHT;
   endfunction

   // advance the predictor by one accepted input beat
   function automatic void predict_blur(input pixel_type pixel_in, input logic pad);
      int unsigned w, h, n, sum_r, sum_g, sum_b;
      pixel_type   top, mid, px, v;
      logic        emit;
      blurred_type res;
      w = active_width();
      h = active_height();
      // padding while the frame still wants pixels is dropped
      if (in_row < h && pad) return;
      // once all pixels are in, pixel data is thrown away
      px  = (in_row >= h) ? pixel_type'(24'd0) : pixel_in;
      top = upper_row[in_col];
      mid = middle_row[in_col];
      upper_row[in_col]  = mid;
      middle_row[in_col] = px;
      for (int k = 0; k < 6; k++) window_px[k] = window_px[k + 3];
      window_px[6] = top;
      window_px[7] = mid;
      window_px[8] = px;
      // the center pixel is one row and one column behind the input
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return;
      n     = 0;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      // leave out neighbors outside the frame
      for (int j = 0; j < 3; j++) begin
         if (j == 0 && out_col == 0) continue;
         if (j == 2 && out_col + 1 >= w) continue;
         for (int i = 0; i < 3; i++) begin
            if (i == 0 && out_row == 0) continue;
            if (i == 2 && out_row + 1 >= h) continue;
            v = window_px[j * 3 + i];
            sum_r += v.red;
            sum_g += v.green;
            sum_b += v.blue;
            n++;
         end
      end
      // round half up
      res.px.red    = 8'((2 * sum_r + n) / (2 * n));
      res.px.green  = 8'((2 * sum_g + n) / (2 * n));
      res.px.blue   = 8'((2 * sum_b + n) / (2 * n));
      res.frame_end = (out_col + 1 >= w) && (out_row + 1 >= h);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (res.frame_end) begin
         restart_frame();
         frame_closed = 1'b1;
         frames_closed++;
      end
      expected_blur.push_back(res);
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      p = 24'($urandom);
      if (extreme_px) begin
         p.red   = {8{p.red[0]}};
         p.green = {8{p.green[0]}};
         p.blue  = {8{p.blue[0]}};
      end
      return p;
   endfunction

   // one input beat, with a random idle gap ahead of it
   task automatic send_beat(input pixel_type px, input logic pad);
      while (!burst && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {px.blue, px.green, px.red};
      req_tuser  <= pad;
      do @(posedge clock); while (!req_tready);
      if (pad) pads_sent++;
      else pixels_sent++;
      predict_blur(px, pad);
   endtask

   task automatic send_pixels(input int unsigned count, input int pad_pct);
      for (int unsigned p = 0; p < count; p++) begin
         if ($urandom_range(99) < pad_pct) send_beat(random_pixel(), 1'b1);
         send_beat(random_pixel(), 1'b0);
      end
   endtask

   // mostly padding, some pixel beats that only push the drain along
   task automatic drain_frame();
      while (!frame_closed) send_beat(random_pixel(), $urandom_range(99) < 70);
   endtask

   task automatic run_frame(input int pad_pct);
      frame_closed = 1'b0;
      send_pixels(active_width() * active_height(), pad_pct);
      drain_frame();
   endtask

   // wait for every expected result, then let the pipeline go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_blur.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high, the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
      case (idx)
         REG_FRAME_WIDTH: begin
            blur_width = value[WCFG_W-1:0];
            restart_frame();
         end
         REG_FRAME_HEIGHT: begin
            blur_height = value;
            restart_frame();
         end
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] width_word,
                            input logic [CSR_DATA_W-1:0] height_word);
      settle();
      write_reg(REG_FRAME_WIDTH, width_word);
      write_reg(REG_FRAME_HEIGHT, height_word);
      csr_valid <= 1'b0;
   endtask

   // compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_blur.size() == 0) begin
            report_mismatch($sformatf("result beat %h last %b with nothing expected",
                                      rsp_tdata, rsp_tlast));
         end else begin
            next_blur = expected_blur.pop_front();
            if (rsp_tdata[7:0] !== next_blur.px.red)
               report_mismatch($sformatf("red %0d, expected %0d",
                                         rsp_tdata[7:0], next_blur.px.red));
            if (rsp_tdata[15:8] !== next_blur.px.green)
               report_mismatch($sformatf("green %0d, expected %0d",
                                         rsp_tdata[15:8], next_blur.px.green));
            if (rsp_tdata[23:16] !== next_blur.px.blue)
               report_mismatch($sformatf("blue %0d, expected %0d",
                                         rsp_tdata[23:16], next_blur.px.blue));
            if (rsp_tlast !== next_blur.frame_end)
               report_mismatch($sformatf("frame end %b, expected %b",
                                         rsp_tlast, next_blur.frame_end));
         end
      end
   end

   // hang detection: any accepted beat on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no beat for %0d cycles, %0d results outstanding",
                  idle_cycles, expected_blur.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // sizes straight out of reset, first rows of a 640 x 480 frame, no idling
   task automatic test_reset_sizes();
      burst = 1'b1;
      frame_closed = 1'b0;
      send_pixels(650, 5);
      burst = 1'b0;
   endtask

   // tiny frames with full-scale channels
   task automatic test_edges_directed();
      extreme_px = 1'b1;
      // zero width and height both act as one: single pixel, divisor one
      configure('0, '0);
      run_frame(0);
      // 3 x 3: corners, edges and one full neighborhood
      configure(16'd3, 16'd3);
      frame_closed = 1'b0;
      send_beat(random_pixel(), 1'b1);  // padding at frame start is dropped
      send_pixels(3, 0);
      // writes to unused indexes must not restart the frame
      settle();
      write_reg(REG_UNUSED_2, 16'($urandom));
      write_reg(REG_UNUSED_3, 16'($urandom));
      csr_valid <= 1'b0;
      send_pixels(6, 30);
      drain_frame();
      extreme_px = 1'b0;
   endtask

   task automatic test_size_extremes();
      // upper data bits of the width word are ignored
      configure(16'hF003, 16'd2);
      run_frame(3);
      // one pixel wide, tallest frame, abandoned after a few rows
      configure(16'd1, 16'hFFFF);
      frame_closed = 1'b0;
      send_pixels(40, 10);
   endtask

   // small random frames, back to back or after a resize, some cut short
   task automatic test_random_frames();
      int unsigned start_beats, w, h;
      bit          need_config;
      start_beats = pixels_sent + pads_sent;
      need_config = 1'b1;
      while (pixels_sent + pads_sent - start_beats < RANDOM_BEATS) begin
         if (need_config || $urandom_range(99) < 60) begin
            w = ($urandom_range(99) < 85) ? $urandom_range(8, 0) : $urandom_range(40, 9);
            h = ($urandom_range(99) < 85) ? $urandom_range(6, 0) : $urandom_range(12, 7);
            configure({4'($urandom), 12'(w)}, 16'(h));
            need_config = 1'b0;
         end
         if ($urandom_range(99) < 10) begin
            // broken frame, the next resize throws it away
            frame_closed = 1'b0;
            send_pixels($urandom_range(active_width() * active_height(), 1), 5);
            need_config = 1'b1;
         end else begin
            run_frame(5);
         end
      end
   endtask

   initial begin
      reset_blur_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_sizes();
      test_edges_directed();
      test_size_extremes();
      test_random_frames();
      settle();
      $display("sent %0d pixel and %0d padding beats, %0d register writes",
               pixels_sent, pads_sent, reg_writes);
      $display("checked %0d blurred pixels, %0d frames completed, %0d mismatches",
               results_seen, frames_closed, errors);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/bb3_pkg.sv
sv/bb3_mean.sv
sv/box_blur_3x3_edge_aware_unit.sv
sv/bb3_checker.sv
dv/box_blur_3x3_edge_aware_unit_tb.sv
